>>> rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_MAX_BLOCKS  = 1024;
  localparam int unsigned DEF_BLOCK_BYTES = 16;

  // Fixed sizes
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned WORD_BITS  = 32;

  // Field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RES_W    = 14;
  localparam int unsigned PAGES_W  = 3;

  localparam int unsigned NUM_PAGE_CODES = 2 ** PAGES_W;
  localparam logic [PAGES_W-1:0] REGION_PAGES_RST = PAGES_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_ZERO       = 3'd1,
    STATUS_TOO_BIG    = 3'd2,
    STATUS_NO_RUN     = 3'd3,
    STATUS_OOB        = 3'd4,
    STATUS_MISALIGNED = 3'd5,
    STATUS_RANGE      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_MARK,
    S_RESP
  } state_e;

endpackage

>>> rtl/core/bfa_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_cfg_if
// Configuration write channel: region size in pages.
// ----------------------------------------------------------------------------
interface bfa_cfg_if;
  import bfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [PAGES_W-1:0] region_pages;

  modport source (output valid, output region_pages, input ready);
  modport sink   (input valid, input region_pages, output ready);
endinterface

>>> rtl/core/bfa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: allocate or free command with size and offset.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  import bfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFFS_W-1:0] offset_bytes;

  modport source (output valid, output cmd, output size_bytes, output offset_bytes,
                  input ready);
  modport sink   (input valid, input cmd, input size_bytes, input offset_bytes,
                  output ready);
endinterface

>>> rtl/core/bfa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: status and allocated byte offset.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RES_W-1:0]    result_offset;

  modport source (output valid, output status, output result_offset, input ready);
  modport sink   (input valid, input status, input result_offset, output ready);
endinterface

>>> rtl/core/bfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bitmap_first_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// First-fit block allocator over a one-bit-per-block free map kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : allocate (size) or free (offset, size) item, valid/ready.
//   rsp_o  : one item per request, status and byte offset, valid/ready.
//   cfg_i  : region size in pages, for the user to write only while idle.
// The block has no check of this. One request is worked on at a time. The free
// map sits in a RAM of 32-bit words with one read and one write port; scan and
// marking each move one word per cycle, so the read port sets the rate.
//   allocate : scans the words up to the hit (all words of the region on a miss),
//              then marks the words touched by the run.
//   free     : marks the words touched by the run.
// Rejected items of either kind go straight to the response.
// The next request can be taken in the cycle after the last response is loaded.
// Reset marks every block free at once through per-word valid bits; no
// clearing pass is needed. The region register resets to 4 pages.
// The response sits in an output register: a new request is taken while it
// waits, and the next response waits until the receiver takes the old one.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAX_BLOCKS  = bfa_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned BLOCK_BYTES = bfa_pkg::DEF_BLOCK_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_cfg_if.sink   cfg_i,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned NUM_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned WA_W      = $clog2(NUM_WORDS);
  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned BB_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int unsigned TB_W      = CNT_W + BB_SHIFT;
  localparam int unsigned CMP_W     = (TB_W > SIZE_W + 1) ? TB_W : SIZE_W + 1;
  localparam int unsigned SZ1_W     = SIZE_W + 1;
  localparam int unsigned NB_W      = SZ1_W - BB_SHIFT;
  localparam int unsigned FB_W      = OFFS_W - BB_SHIFT;
  localparam int unsigned RNG_W     = (NB_W + 1 > CNT_W) ? NB_W + 1 : CNT_W;
  localparam int unsigned OW_W      = IDX_W + BB_SHIFT + RES_W;
  localparam int unsigned LVLS      = BIT_W;

  // --------------------------------------------------------------------------
  // Region size
  // --------------------------------------------------------------------------
  logic [PAGES_W-1:0] pages_q;
  logic [CNT_W-1:0]   total_lut [NUM_PAGE_CODES];
  logic [CNT_W-1:0]   region_blks;
  logic [TB_W-1:0]    total_bytes;
  logic [IDX_W-1:0]   last_blk;
  logic [WA_W-1:0]    last_word;
  logic [BIT_W-1:0]   last_bit;

  for (genvar g = 0; g < NUM_PAGE_CODES; g++) begin : g_total
    // a page count of zero acts as one page
    localparam int unsigned PG  = (g == 0) ? 1 : g;
    localparam int unsigned RAW = PG * PAGE_BYTES / BLOCK_BYTES;
    localparam int unsigned TOT = (RAW > MAX_BLOCKS) ? MAX_BLOCKS : RAW;
    assign total_lut[g] = CNT_W'(TOT);
  end

  assign region_blks = total_lut[pages_q];
  assign total_bytes = {region_blks, {BB_SHIFT{1'b0}}};
  assign last_blk    = IDX_W'(region_blks - CNT_W'(1));
  assign last_word   = last_blk[IDX_W-1:BIT_W];
  assign last_bit    = last_blk[BIT_W-1:0];

  // --------------------------------------------------------------------------
  // State and registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  cmd_e              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFFS_W-1:0] off_q;

  logic [CNT_W-1:0]  need_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic              set_free_q;
  status_e           status_q;
  logic [RES_W-1:0]  res_q;

  logic [WA_W-1:0]   srch_addr_q;
  logic              srch_issue_q;
  logic [CNT_W-1:0]  run_q;
  logic              s1_vld_q;
  logic [WA_W-1:0]   s1_word_q;
  logic              s2_vld_q;
  logic [WA_W-1:0]   s2_word_q;
  logic              s2_all_q [WORD_BITS];
  logic [BIT_W:0]    s2_suf_q [WORD_BITS];

  logic [WA_W-1:0]   mk_addr_q;
  logic              mk_issue_q;
  logic              m1_vld_q;
  logic [WA_W-1:0]   m1_word_q;

  logic [NUM_WORDS-1:0] map_vld_q;
  logic                 row_vld_q;

  logic                rsp_vld_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [RES_W-1:0]    rsp_off_q;

  // --------------------------------------------------------------------------
  // Free map RAM
  // --------------------------------------------------------------------------
  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] map_word;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (m1_word_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // a row never written reads as all free
  assign map_word = row_vld_q ? rd_data : '1;

  // --------------------------------------------------------------------------
  // Request checks
  // --------------------------------------------------------------------------
  logic [SZ1_W-1:0] sz_sum;
  logic [NB_W-1:0]  blocks_sz;
  logic [FB_W-1:0]  first_blk;
  logic [RNG_W-1:0] count_w, first_w, range_end;
  logic             size_big, off_oob, off_mis, range_bad;
  status_e          chk_status;

  assign sz_sum    = SZ1_W'(size_q) + SZ1_W'(BLOCK_BYTES - 1);
  assign blocks_sz = sz_sum[SZ1_W-1:BB_SHIFT];
  assign first_blk = off_q[OFFS_W-1:BB_SHIFT];
  assign count_w   = RNG_W'(blocks_sz);
  assign first_w   = RNG_W'(first_blk);
  assign range_end = first_w + count_w;
  assign size_big  = CMP_W'(size_q) > CMP_W'(total_bytes);
  assign off_oob   = CMP_W'(off_q) >= CMP_W'(total_bytes);
  assign off_mis   = off_q[BB_SHIFT-1:0] != '0;
  assign range_bad = range_end > RNG_W'(region_blks);

  always_comb begin
    chk_status = STATUS_OK;
    if (size_q == '0) begin
      chk_status = STATUS_ZERO;
    end else if (cmd_q == CMD_ALLOC) begin
      if (size_big) begin
        chk_status = STATUS_TOO_BIG;
      end
    end else if (off_oob) begin
      chk_status = STATUS_OOB;
    end else if (off_mis) begin
      chk_status = STATUS_MISALIGNED;
    end else if (range_bad) begin
      chk_status = STATUS_RANGE;
    end
  end

  // --------------------------------------------------------------------------
  // Search stage A: run lengths inside one word (prefix tree)
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] srch_word;
  logic                 all_l [LVLS+1][WORD_BITS];
  logic [BIT_W:0]       suf_l [LVLS+1][WORD_BITS];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      // blocks past the region end count as used
      srch_word[b] = map_word[b] &
                     ((s1_word_q != last_word) || (BIT_W'(b) <= last_bit));
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      all_l[0][b] = srch_word[b];
      suf_l[0][b] = (BIT_W + 1)'(srch_word[b]);
    end
    for (int lv = 0; lv < LVLS; lv++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (b >= (1 << lv)) begin
          all_l[lv+1][b] = all_l[lv][b] & all_l[lv][b-(1<<lv)];
          suf_l[lv+1][b] = all_l[lv][b] ? suf_l[lv][b] + suf_l[lv][b-(1<<lv)]
                                         : suf_l[lv][b];
        end else begin
          all_l[lv+1][b] = all_l[lv][b];
          suf_l[lv+1][b] = suf_l[lv][b];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Search stage B: carry in the open run, find the first fit
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] eff     [WORD_BITS];
  logic [WORD_BITS-1:0] hit;
  logic             hit_any;
  logic [BIT_W-1:0] hit_bit;
  logic [IDX_W-1:0] hit_hi, hit_lo;
  logic [CNT_W-1:0] run_next;
  logic [OW_W-1:0]  hit_off;
  logic             srch_hit, srch_miss;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      eff[b] = s2_all_q[b] ? run_q + CNT_W'(b + 1) : CNT_W'(s2_suf_q[b]);
      hit[b] = eff[b] >= need_q;
    end
    hit_any = 1'b0;
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (hit[b]) begin
        hit_any = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign hit_hi    = {s2_word_q, hit_bit};
  assign hit_lo    = hit_hi - need_q[IDX_W-1:0] + IDX_W'(1);
  assign hit_off   = OW_W'(hit_lo) << BB_SHIFT;
  assign run_next  = s2_all_q[WORD_BITS-1] ? run_q + CNT_W'(WORD_BITS)
                                           : CNT_W'(s2_suf_q[WORD_BITS-1]);
  assign srch_hit  = (state_q == S_SEARCH) && s2_vld_q && hit_any;
  assign srch_miss = (state_q == S_SEARCH) && s2_vld_q && !hit_any &&
                     (s2_word_q == last_word);

  // --------------------------------------------------------------------------
  // Marking: read-modify-write of each word of the run
  // --------------------------------------------------------------------------
  logic [WA_W-1:0]      lo_word, hi_word;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic [WORD_BITS-1:0] mk_mask;
  logic                 mk_done;

  assign lo_word = lo_q[IDX_W-1:BIT_W];
  assign hi_word = hi_q[IDX_W-1:BIT_W];
  assign lo_bit  = (m1_word_q == lo_word) ? lo_q[BIT_W-1:0] : '0;
  assign hi_bit  = (m1_word_q == hi_word) ? hi_q[BIT_W-1:0] : '1;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mk_mask[b] = (BIT_W'(b) >= lo_bit) && (BIT_W'(b) <= hi_bit);
    end
  end

  assign wr_en   = (state_q == S_MARK) && m1_vld_q;
  assign wr_data = set_free_q ? (map_word | mk_mask) : (map_word & ~mk_mask);
  assign mk_done = wr_en && (m1_word_q == hi_word);

  // --------------------------------------------------------------------------
  // FSM: next state
  // --------------------------------------------------------------------------
  logic req_acc, rsp_load;

  assign req_acc  = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == S_RESP) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status != STATUS_OK) begin
          state_d = S_RESP;
        end else if (cmd_q == CMD_ALLOC) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_MARK;
        end
      end
      S_SEARCH: begin
        if (srch_hit) begin
          state_d = S_MARK;
        end else if (srch_miss) begin
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        if (mk_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // FSM: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = srch_addr_q;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
      end
      S_SEARCH: begin
        rd_en   = srch_issue_q;
        rd_addr = srch_addr_q;
      end
      S_MARK: begin
        rd_en   = mk_issue_q;
        rd_addr = mk_addr_q;
      end
      S_CHECK, S_RESP: begin
        rd_en = 1'b0;
      end
      default: rd_en = 1'b0;
    endcase
  end

  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.result_offset = rsp_off_q;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pages_q      <= REGION_PAGES_RST;
      srch_issue_q <= 1'b0;
      mk_issue_q   <= 1'b0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      m1_vld_q     <= 1'b0;
      rsp_vld_q    <= 1'b0;
      map_vld_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        pages_q <= cfg_i.region_pages;
      end

      // scan issue
      if (state_q == S_CHECK) begin
        srch_issue_q <= 1'b1;
      end else if (state_q == S_SEARCH && srch_issue_q && srch_addr_q == last_word) begin
        srch_issue_q <= 1'b0;
      end
      s1_vld_q <= (state_q == S_SEARCH) && srch_issue_q && !srch_hit;
      s2_vld_q <= (state_q == S_SEARCH) && s1_vld_q && !srch_hit;

      // mark issue
      if ((state_q == S_CHECK && state_d == S_MARK) || srch_hit) begin
        mk_issue_q <= 1'b1;
      end else if (state_q == S_MARK && mk_issue_q && mk_addr_q == hi_word) begin
        mk_issue_q <= 1'b0;
      end
      m1_vld_q <= (state_q == S_MARK) && mk_issue_q;

      if (wr_en) begin
        map_vld_q[m1_word_q] <= 1'b1;
      end

      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q  <= cmd_e'(req_i.cmd);
      size_q <= req_i.size_bytes;
      off_q  <= req_i.offset_bytes;
    end

    if (rd_en) begin
      row_vld_q <= map_vld_q[rd_addr];
    end

    if (state_q == S_CHECK) begin
      status_q    <= chk_status;
      res_q       <= '0;
      need_q      <= count_w[CNT_W-1:0];
      lo_q        <= first_w[IDX_W-1:0];
      hi_q        <= IDX_W'(range_end - RNG_W'(1));
      set_free_q  <= (cmd_q == CMD_FREE);
      srch_addr_q <= '0;
      mk_addr_q   <= first_w[IDX_W-1:BIT_W];
      run_q       <= '0;
    end

    if (state_q == S_SEARCH) begin
      if (srch_issue_q) begin
        srch_addr_q <= srch_addr_q + WA_W'(1);
      end
      s1_word_q <= srch_addr_q;
      s2_word_q <= s1_word_q;
      for (int b = 0; b < WORD_BITS; b++) begin
        s2_all_q[b] <= all_l[LVLS][b];
        s2_suf_q[b] <= suf_l[LVLS][b];
      end
      if (s2_vld_q) begin
        run_q <= run_next;
      end
      if (srch_hit) begin
        lo_q      <= hit_lo;
        hi_q      <= hit_hi;
        mk_addr_q <= hit_lo[IDX_W-1:BIT_W];
        res_q     <= hit_off[RES_W-1:0];
      end else if (srch_miss) begin
        status_q <= STATUS_NO_RUN;
      end
    end

    if (state_q == S_MARK) begin
      if (mk_issue_q) begin
        mk_addr_q <= mk_addr_q + WA_W'(1);
      end
      m1_word_q <= mk_addr_q;
    end

    if (rsp_load) begin
      rsp_status_q <= status_q;
      rsp_off_q    <= res_q;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap first-fit block allocator. A queue-fed
// driver sends allocate and free requests, and a clocked monitor compares
// each response with a free-map predictor kept in the bench. The run covers
// every status code and several region sizes. Both sides stall at random.
// One long response hold-off lets the block back up.
// ----------------------------------------------------------------------------
module testbench;
  import bfa_pkg::*;

  localparam int unsigned MAX_BLK          = DEF_MAX_BLOCKS;
  localparam int unsigned BLK_BYTES        = DEF_BLOCK_BYTES;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned STALL_LIMIT      = 5000;
  localparam int unsigned TAIL_CYCLES      = 100;
  localparam int unsigned PENDING_DEPTH    = 4;
  localparam int unsigned RANDOM_PER_PHASE = 135;

  typedef struct {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] offset;
  } request_t;

  typedef struct {
    request_t         rq;
    status_e          status;
    logic [RES_W-1:0] result_offset;
  } response_t;

  typedef struct {
    int unsigned offset;
    int unsigned size;
  } run_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bfa_cfg_if cfg_ch ();
  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_first_fit_allocator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always #6ns clk_i = ~clk_i;

  // Predictor state: 1 = block free
  bit                 block_free [MAX_BLK];
  logic [PAGES_W-1:0] region_pages_q = REGION_PAGES_RST;

  request_t    pending_q [$];
  response_t   expected_q [$];
  run_t        live_runs [$];
  request_t    drv_rq;
  request_t    accepted_rq;
  response_t   exp_rsp;
  int unsigned page_plan [8] = '{1, 0, 7, 2, 5, 3, 6, 4};
  bit          idle_on      = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;

  function automatic int unsigned region_blocks();
    int unsigned pages;
    int unsigned n;
    pages = (region_pages_q == '0) ? 1 : region_pages_q;
    n = pages * PAGE_BYTES / BLK_BYTES;
    return (n > MAX_BLK) ? MAX_BLK : n;
  endfunction

  // Works out the response of one request and updates the free map.
  function automatic response_t allocator_response(input request_t rq);
    response_t   rsp;
    int unsigned total;
    int unsigned need;
    int unsigned start;
    int unsigned run_len;
    int unsigned base_blk;
    bit          found;
    total   = region_blocks();
    need    = (rq.size + BLK_BYTES - 1) / BLK_BYTES;
    start   = 0;
    run_len = 0;
    found   = 1'b0;
    rsp.rq            = rq;
    rsp.status        = STATUS_OK;
    rsp.result_offset = '0;
    if (rq.size == 0) begin
      rsp.status = STATUS_ZERO;
    end else if (rq.cmd == CMD_ALLOC) begin
      if (rq.size > total * BLK_BYTES) begin
        rsp.status = STATUS_TOO_BIG;
      end else begin
        for (int unsigned i = 0; i < total && !found; i++) begin
          if (block_free[i]) begin
            if (run_len == 0) start = i;
            run_len++;
            if (run_len == need) found = 1'b1;
          end else begin
            run_len = 0;
          end
        end
        if (found) begin
          for (int unsigned i = start; i < start + need; i++) block_free[i] = 1'b0;
          rsp.result_offset = RES_W'(start * BLK_BYTES);
        end else begin
          rsp.status = STATUS_NO_RUN;
        end
      end
    end else if (rq.offset >= total * BLK_BYTES) begin
      rsp.status = STATUS_OOB;
    end else if (rq.offset % BLK_BYTES != 0) begin
      rsp.status = STATUS_MISALIGNED;
    end else begin
      base_blk = rq.offset / BLK_BYTES;
      if (base_blk + need > total) begin
        rsp.status = STATUS_RANGE;
      end else begin
        for (int unsigned i = base_blk; i < base_blk + need; i++) block_free[i] = 1'b1;
      end
    end
    return rsp;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_on || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid        <= 1'b0;
      req_ch.cmd          <= CMD_ALLOC;
      req_ch.size_bytes   <= '0;
      req_ch.offset_bytes <= '0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        accepted_rq.cmd    = cmd_e'(req_ch.cmd);
        accepted_rq.size   = req_ch.size_bytes;
        accepted_rq.offset = req_ch.offset_bytes;
        expected_q.push_back(allocator_response(accepted_rq));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drv_rq = pending_q.pop_front();
          req_ch.cmd          <= drv_rq.cmd;
          req_ch.size_bytes   <= drv_rq.size;
          req_ch.offset_bytes <= drv_rq.offset;
          req_ch.valid        <= 1'b1;
          send_gap = draw_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response item: status %0d result_offset %0d",
                 rsp_ch.status, rsp_ch.result_offset);
          mismatch_cnt++;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_ch.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_ch.status);
            mismatch_cnt++;
          end
          if (rsp_ch.result_offset !== exp_rsp.result_offset) begin
            $error("result_offset: expected %0d, actual %0d",
                   exp_rsp.result_offset, rsp_ch.result_offset);
            mismatch_cnt++;
          end
          // successful allocations become candidates for well-formed frees
          if (exp_rsp.rq.cmd == CMD_ALLOC && exp_rsp.status == STATUS_OK)
            live_runs.push_back('{exp_rsp.result_offset, exp_rsp.rq.size});
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        recv_gap = draw_gap();
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input cmd_e cmd, input int unsigned size, input int unsigned offset);
    request_t rq;
    rq.cmd    = cmd;
    rq.size   = SIZE_W'(size);
    rq.offset = OFFS_W'(offset);
    while (pending_q.size() >= PENDING_DEPTH) @(negedge clk_i);
    pending_q.push_back(rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
  endtask

  task automatic write_region(input int unsigned pages);
    @(posedge clk_i);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.region_pages <= PAGES_W'(pages);
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    region_pages_q = PAGES_W'(pages);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned r;
    int unsigned s;
    int unsigned total;
    int unsigned size;
    int unsigned idx;
    run_t        run;
    for (int unsigned n = 0; n < count; n++) begin
      total = region_blocks();
      r = $urandom_range(99);
      if (n % 50 == 49) begin
        // sender pause; sometimes release the whole region afterwards
        wait_drained();
        if ($urandom_range(1) == 1) begin
          live_runs.delete();
          push_item(CMD_FREE, total * BLK_BYTES, 0);
        end
      end else if (r < 45) begin
        s = $urandom_range(99);
        if (s < 70)      size = $urandom_range(256, 1);
        else if (s < 90) size = $urandom_range(2048, 257);
        else if (s < 97) size = $urandom_range(total * BLK_BYTES, 1);
        else             size = $urandom_range(65535);
        push_item(CMD_ALLOC, size, $urandom_range(65535));
      end else if (r < 80 && live_runs.size() != 0) begin
        idx = $urandom_range(live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        push_item(CMD_FREE, run.size, run.offset);
      end else if (r < 90) begin
        push_item(CMD_FREE, $urandom_range(512, 1), $urandom_range(total - 1) * BLK_BYTES);
      end else if (r < 95) begin
        push_item(cmd_e'($urandom_range(1)), $urandom_range(65535), $urandom_range(65535));
      end else begin
        push_item(cmd_e'($urandom_range(1)), 0, $urandom_range(65535));
      end
    end
  endtask

  initial begin
    cfg_ch.valid        = 1'b0;
    cfg_ch.region_pages = REGION_PAGES_RST;
    foreach (block_free[i]) block_free[i] = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset region size (16 KiB)
    push_item(CMD_ALLOC, 0, 0);          // zero size
    push_item(CMD_FREE, 0, 0);
    push_item(CMD_ALLOC, 1, 65535);      // rounds up to one block
    push_item(CMD_ALLOC, 16, 0);
    push_item(CMD_ALLOC, 17, 0);         // two blocks
    push_item(CMD_ALLOC, 16385, 0);      // larger than region
    push_item(CMD_ALLOC, 65535, 0);
    push_item(CMD_ALLOC, 16384, 0);      // fits region, no run left
    push_item(CMD_FREE, 16, 16384);      // offset at region end
    push_item(CMD_FREE, 16, 65535);
    push_item(CMD_FREE, 16, 8);          // misaligned
    push_item(CMD_FREE, 65535, 16383);   // in bounds but misaligned
    push_item(CMD_FREE, 32, 16368);      // runs past last block
    push_item(CMD_FREE, 16, 16368);      // already free, stays free
    push_item(CMD_FREE, 16384, 0);       // whole region
    push_item(CMD_ALLOC, 16384, 0);      // whole region taken
    push_item(CMD_ALLOC, 1, 0);          // no run
    push_item(CMD_FREE, 65535, 0);       // range too large
    push_item(CMD_FREE, 16384, 0);
    wait_drained();
    run_random(RANDOM_PER_PHASE);

    foreach (page_plan[p]) begin
      wait_drained();
      write_region(page_plan[p]);
      idle_on = (p % 3 != 1);
      if (p == 2) hold_request = 1'b1;
      run_random(RANDOM_PER_PHASE);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_cfg_if.sv
rtl/core/bfa_req_if.sv
rtl/core/bfa_rsp_if.sv
rtl/core/bfa_ram.sv
rtl/core/bitmap_first_fit_allocator_core.sv
tb/testbench.sv
